/* rtl/core/vsd_pkg.sv */
package vsd_pkg;

   // Code and frame geometry
   localparam int MEMORY    = 6;
   localparam int NSTATES   = 1 << MEMORY;
   localparam int STEPS_MAX = 64;
   localparam int SOFT_BITS = 8;

   // Port widths fixed by the item layout
   localparam int SOFT_W      = 8;
   localparam int BIT_INDEX_W = 6;
   localparam int CFG_W       = 7;
   localparam int CSR_IDX_W   = 1;

   // Internal widths
   localparam int METRIC_W = 20;
   localparam int BM_W     = SOFT_BITS + 1;
   localparam int CNT_W    = $clog2(STEPS_MAX + 1);
   localparam int IDX_W    = $clog2(STEPS_MAX);
   localparam int ACS_W    = MEMORY + 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GEN_FIRST  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GEN_SECOND = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] GEN_FIRST_RESET  = CFG_W'(121);
   localparam logic [CFG_W-1:0] GEN_SECOND_RESET = CFG_W'(91);

   typedef logic signed [METRIC_W-1:0] metric_type;
   typedef logic signed [METRIC_W:0]   metric_wide_type;

   localparam metric_type      METRIC_START = METRIC_W'(65536);
   localparam metric_wide_type METRIC_MAX   = (METRIC_W + 1)'((1 << (METRIC_W - 1)) - 1);
   localparam metric_wide_type METRIC_MIN   = -(METRIC_W + 1)'(1 << (METRIC_W - 1));

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_ACS      = 6'b000010,
      ST_TB_START = 6'b000100,
      ST_TB_RD    = 6'b001000,
      ST_TB_UPD   = 6'b010000,
      ST_EMIT     = 6'b100000
   } state_type;

   // Saturate a grown sum back into the metric range
   function automatic metric_type clamp_metric(input metric_wide_type v);
      metric_type r;
      if (v > METRIC_MAX) begin
         r = METRIC_MAX[METRIC_W-1:0];
      end else if (v < METRIC_MIN) begin
         r = METRIC_MIN[METRIC_W-1:0];
      end else begin
         r = v[METRIC_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/viterbi_soft_decoder_rate_half.sv */
// Item: one shared add-compare-select unit visits one target state per cycle, behind registered
// metric reads; a dropped step skips the add-compare-select pass.
// Item with frame end: when n > MEMORY, traceback reads one survivor word for each of the n stored
// steps (a read state, then an update state), then emits n-MEMORY results, one per cycle.
// Results carry no back-pressure; each strobe lasts one cycle.
// Synchronous reset clears the step count and overflow, restarts the metrics and loads the reset taps.
module viterbi_soft_decoder_rate_half (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [vsd_pkg::SOFT_W-1:0]          req_soft_first,
   input  logic [vsd_pkg::SOFT_W-1:0]          req_soft_second,
   input  logic                                req_frame_end,
   output logic                                rsp_strobe,
   output logic [vsd_pkg::BIT_INDEX_W-1:0]     rsp_bit_index,
   output logic                                rsp_decoded_bit,
   output logic                                rsp_last_bit,
   output logic                                rsp_frame_too_long,
   input  logic                                csr_we,
   input  logic [vsd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vsd_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int M   = vsd_pkg::MEMORY;
   localparam int NS  = vsd_pkg::NSTATES;
   localparam int SB  = vsd_pkg::SOFT_BITS;
   localparam int BMW = vsd_pkg::BM_W;
   localparam int MW  = vsd_pkg::METRIC_W;
   localparam int CW  = vsd_pkg::CNT_W;
   localparam int IW  = vsd_pkg::IDX_W;
   localparam int AW  = vsd_pkg::ACS_W;

   // Control registers
   vsd_pkg::state_type state_ff, state_in;
   logic [vsd_pkg::CFG_W-1:0] gen_first_ff, gen_first_in;
   logic [vsd_pkg::CFG_W-1:0] gen_second_ff, gen_second_in;
   logic [CW-1:0]  step_cnt_ff, step_cnt_in;
   logic           overflow_ff, overflow_in;
   logic           fresh_ff, fresh_in;
   logic           bank_ff, bank_in;
   logic           p_valid_ff, p_valid_in;
   logic           rsp_strobe_ff, rsp_strobe_in;

   // Working registers
   logic [AW-1:0]        acs_cnt_ff, acs_cnt_in;
   logic [M-1:0]         ns_p_ff, ns_p_in;
   logic [NS-1:0]        dec_ff, dec_in;
   logic                 frame_end_ff, frame_end_in;
   logic signed [SB-1:0] soft0_ff, soft0_in;
   logic signed [SB-1:0] soft1_ff, soft1_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [IW-1:0]        tb_idx_ff, tb_idx_in;
   logic [M-1:0]         s_ff, s_in;
   logic [vsd_pkg::STEPS_MAX-1:0] bits_ff, bits_in;
   logic [IW-1:0]        em_idx_ff, em_idx_in;
   logic [vsd_pkg::BIT_INDEX_W-1:0] rsp_bit_index_ff, rsp_bit_index_in;
   logic                 rsp_decoded_bit_ff, rsp_decoded_bit_in;
   logic                 rsp_last_bit_ff, rsp_last_bit_in;
   logic                 rsp_flag_ff, rsp_flag_in;

   // Path metric banks and survivor store
   vsd_pkg::metric_type pm_a [NS];
   vsd_pkg::metric_type pm_b [NS];
   vsd_pkg::metric_type pm_a_rd0_ff, pm_a_rd1_ff, pm_b_rd0_ff, pm_b_rd1_ff;
   logic [NS-1:0]       surv_mem [vsd_pkg::STEPS_MAX];
   logic [NS-1:0]       surv_rd_ff;

   // Datapath nets
   logic [M-1:0]   issue_ns;
   logic [M-1:0]   rd_addr0, rd_addr1;
   logic           pm_we, surv_we, acs_last;
   logic [M:0]     reg0, reg1, g1, g2;
   logic signed [BMW-1:0] w0, w1;
   vsd_pkg::metric_type old0, old1, cand0, cand1, new_metric;
   logic           pick1;
   logic [NS-1:0]  dec_word;

   assign busy               = (state_ff != vsd_pkg::ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_bit_index      = rsp_bit_index_ff;
   assign rsp_decoded_bit    = rsp_decoded_bit_ff;
   assign rsp_last_bit       = rsp_last_bit_ff;
   assign rsp_frame_too_long = rsp_flag_ff;

   // Read addresses: the two predecessors of the target state being issued
   assign issue_ns = acs_cnt_ff[M-1:0];
   assign rd_addr0 = {issue_ns[M-2:0], 1'b0};
   assign rd_addr1 = {issue_ns[M-2:0], 1'b1};

   // Add-compare-select on the target state whose metrics just came back
   always_comb begin
      g1   = gen_first_ff[M:0];
      g2   = gen_second_ff[M:0];
      reg0 = {ns_p_ff[M-1], ns_p_ff[M-2:0], 1'b0};
      reg1 = {ns_p_ff[M-1], ns_p_ff[M-2:0], 1'b1};
      w0   = ((^(g1 & reg0)) ? BMW'(soft0_ff) : BMW'(0))
           + ((^(g2 & reg0)) ? BMW'(soft1_ff) : BMW'(0));
      w1   = ((^(g1 & reg1)) ? BMW'(soft0_ff) : BMW'(0))
           + ((^(g2 & reg1)) ? BMW'(soft1_ff) : BMW'(0));
      if (fresh_ff) begin
         old0 = (ns_p_ff[M-2:0] == '0) ? vsd_pkg::METRIC_START : '0;
         old1 = '0;
      end else if (bank_ff) begin
         old0 = pm_b_rd0_ff;
         old1 = pm_b_rd1_ff;
      end else begin
         old0 = pm_a_rd0_ff;
         old1 = pm_a_rd1_ff;
      end
      cand0 = vsd_pkg::clamp_metric((MW + 1)'(old0) + (MW + 1)'(w0));
      cand1 = vsd_pkg::clamp_metric((MW + 1)'(old1) + (MW + 1)'(w1));
      // ties keep the lower source state
      pick1      = (cand1 > cand0);
      new_metric = pick1 ? cand1 : cand0;
      dec_word          = dec_ff;
      dec_word[ns_p_ff] = pick1;
   end

   assign pm_we    = p_valid_ff;
   assign acs_last = p_valid_ff && (ns_p_ff == M'(NS - 1));
   assign surv_we  = acs_last;

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      gen_first_in     = gen_first_ff;
      gen_second_in    = gen_second_ff;
      step_cnt_in      = step_cnt_ff;
      overflow_in      = overflow_ff;
      fresh_in         = fresh_ff;
      bank_in          = bank_ff;
      p_valid_in       = 1'b0;
      rsp_strobe_in    = 1'b0;
      acs_cnt_in       = acs_cnt_ff;
      ns_p_in          = issue_ns;
      dec_in           = dec_ff;
      frame_end_in     = frame_end_ff;
      soft0_in         = soft0_ff;
      soft1_in         = soft1_ff;
      k_in             = k_ff;
      tb_idx_in        = tb_idx_ff;
      s_in             = s_ff;
      bits_in          = bits_ff;
      em_idx_in        = em_idx_ff;
      rsp_bit_index_in   = rsp_bit_index_ff;
      rsp_decoded_bit_in = rsp_decoded_bit_ff;
      rsp_last_bit_in    = rsp_last_bit_ff;
      rsp_flag_in        = rsp_flag_ff;

      // tap registers
      if (csr_we) begin
         case (csr_index)
            vsd_pkg::CSR_GEN_FIRST:  gen_first_in  = csr_wdata;
            vsd_pkg::CSR_GEN_SECOND: gen_second_in = csr_wdata;
            default: ;
         endcase
      end

      if (pm_we) begin
         dec_in = dec_word;
      end

      case (state_ff)
         vsd_pkg::ST_IDLE: begin
            if (start) begin
               soft0_in     = req_soft_first[SB-1:0];
               soft1_in     = req_soft_second[SB-1:0];
               frame_end_in = req_frame_end;
               if (step_cnt_ff == CW'(vsd_pkg::STEPS_MAX)) begin
                  // full: the step is dropped, the frame end still acts
                  overflow_in = 1'b1;
                  state_in    = req_frame_end ? vsd_pkg::ST_TB_START : vsd_pkg::ST_IDLE;
               end else begin
                  acs_cnt_in = '0;
                  state_in   = vsd_pkg::ST_ACS;
               end
            end
         end

         vsd_pkg::ST_ACS: begin
            if (acs_cnt_ff < AW'(NS)) begin
               acs_cnt_in = acs_cnt_ff + AW'(1);
               p_valid_in = 1'b1;
            end
            if (acs_last) begin
               step_cnt_in = step_cnt_ff + CW'(1);
               bank_in     = ~bank_ff;
               fresh_in    = 1'b0;
               state_in    = frame_end_ff ? vsd_pkg::ST_TB_START : vsd_pkg::ST_IDLE;
            end
         end

         vsd_pkg::ST_TB_START: begin
            if (step_cnt_ff > CW'(M)) begin
               k_in      = step_cnt_ff - CW'(M);
               tb_idx_in = IW'(step_cnt_ff - CW'(1));
               s_in      = '0;
               state_in  = vsd_pkg::ST_TB_RD;
            end else begin
               // short frame: nothing to emit
               step_cnt_in = '0;
               overflow_in = 1'b0;
               fresh_in    = 1'b1;
               state_in    = vsd_pkg::ST_IDLE;
            end
         end

         vsd_pkg::ST_TB_RD: begin
            state_in = vsd_pkg::ST_TB_UPD;
         end

         vsd_pkg::ST_TB_UPD: begin
            if (CW'(tb_idx_ff) < k_ff) begin
               bits_in[tb_idx_ff] = s_ff[M-1];
            end
            s_in = {s_ff[M-2:0], surv_rd_ff[s_ff]};
            if (tb_idx_ff == '0) begin
               em_idx_in = '0;
               state_in  = vsd_pkg::ST_EMIT;
            end else begin
               tb_idx_in = tb_idx_ff - IW'(1);
               state_in  = vsd_pkg::ST_TB_RD;
            end
         end

         vsd_pkg::ST_EMIT: begin
            rsp_strobe_in      = 1'b1;
            rsp_bit_index_in   = vsd_pkg::BIT_INDEX_W'(em_idx_ff);
            rsp_decoded_bit_in = bits_ff[em_idx_ff];
            rsp_last_bit_in    = ((CW'(em_idx_ff) + CW'(1)) == k_ff);
            rsp_flag_in        = overflow_ff;
            em_idx_in          = em_idx_ff + IW'(1);
            if ((CW'(em_idx_ff) + CW'(1)) == k_ff) begin
               step_cnt_in = '0;
               overflow_in = 1'b0;
               fresh_in    = 1'b1;
               state_in    = vsd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = vsd_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vsd_pkg::ST_IDLE;
         gen_first_ff  <= vsd_pkg::GEN_FIRST_RESET;
         gen_second_ff <= vsd_pkg::GEN_SECOND_RESET;
         step_cnt_ff   <= '0;
         overflow_ff   <= 1'b0;
         fresh_ff      <= 1'b1;
         bank_ff       <= 1'b0;
         p_valid_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gen_first_ff  <= gen_first_in;
         gen_second_ff <= gen_second_in;
         step_cnt_ff   <= step_cnt_in;
         overflow_ff   <= overflow_in;
         fresh_ff      <= fresh_in;
         bank_ff       <= bank_in;
         p_valid_ff    <= p_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      acs_cnt_ff         <= acs_cnt_in;
      ns_p_ff            <= ns_p_in;
      dec_ff             <= dec_in;
      frame_end_ff       <= frame_end_in;
      soft0_ff           <= soft0_in;
      soft1_ff           <= soft1_in;
      k_ff               <= k_in;
      tb_idx_ff          <= tb_idx_in;
      s_ff               <= s_in;
      bits_ff            <= bits_in;
      em_idx_ff          <= em_idx_in;
      rsp_bit_index_ff   <= rsp_bit_index_in;
      rsp_decoded_bit_ff <= rsp_decoded_bit_in;
      rsp_last_bit_ff    <= rsp_last_bit_in;
      rsp_flag_ff        <= rsp_flag_in;
   end

   // Metric bank A: new metrics land here when bank B holds the old ones
   always_ff @(posedge clock) begin
      if (pm_we && bank_ff) begin
         pm_a[ns_p_ff] <= new_metric;
      end
      pm_a_rd0_ff <= pm_a[rd_addr0];
      pm_a_rd1_ff <= pm_a[rd_addr1];
   end

   // Metric bank B
   always_ff @(posedge clock) begin
      if (pm_we && !bank_ff) begin
         pm_b[ns_p_ff] <= new_metric;
      end
      pm_b_rd0_ff <= pm_b[rd_addr0];
      pm_b_rd1_ff <= pm_b[rd_addr1];
   end

   // Survivor decisions, one word per stored step
   always_ff @(posedge clock) begin
      if (surv_we) begin
         surv_mem[step_cnt_ff[IW-1:0]] <= dec_word;
      end
      surv_rd_ff <= surv_mem[tb_idx_ff];
   end

   // Checks
   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == vsd_pkg::ST_EMIT))
      else $error("result strobe without emit phase");

   a_acs_only_in_acs: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (state_ff == vsd_pkg::ST_ACS))
      else $error("metric write outside ACS phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      step_cnt_ff <= CW'(vsd_pkg::STEPS_MAX))
      else $error("step count beyond store depth");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_last_bit_ff) |=> !rsp_strobe_ff)
      else $error("result after last bit of run");

endmodule
